FILE: sv/pmst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmst_pkg: shared types and constants
// Beat formats, sizes and the weight-store read request for the
// dense-matrix spanning-tree block.
// ----------------------------------------------------------------------------
package pmst_pkg;

  localparam int unsigned MaxNodes   = 32;
  localparam int unsigned NodeW      = $clog2(MaxNodes);
  localparam int unsigned WeightBits = 16;
  localparam int unsigned KeyW       = WeightBits + 1;
  localparam int unsigned AddrW      = 2 * NodeW;
  localparam int unsigned CntW       = 6;
  localparam int unsigned SumW       = 21;

  localparam logic [CntW-1:0] NodeCountReset = CntW'(MaxNodes);
  localparam logic [KeyW-1:0] KeyInf         = {KeyW{1'b1}};

  typedef struct packed {
    logic [NodeW-1:0]      row;
    logic [NodeW-1:0]      col;
    logic [WeightBits-1:0] weight;
    logic                  last;
  } pmst_in_t;

  typedef struct packed {
    logic [NodeW-1:0]      child_node;
    logic [NodeW-1:0]      parent_node;
    logic [WeightBits-1:0] edge_weight;
    logic [SumW-1:0]       total_weight;
    logic                  reachable;
    logic                  final_res;
  } pmst_out_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
  } pmst_rd_req_t;

endpackage

FILE: sv/pmst_wmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmst_wmem: weight store
// One write port for loading, one read port with registered data for the
// tree sequencer.
// ----------------------------------------------------------------------------
module pmst_wmem (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [pmst_pkg::AddrW-1:0]           waddr_i,
  input  logic [pmst_pkg::WeightBits-1:0]      wdata_i,
  input  pmst_pkg::pmst_rd_req_t               rd_req_i,
  output logic [pmst_pkg::WeightBits-1:0]      rdata_o
);
  import pmst_pkg::*;

  localparam int unsigned Depth = MaxNodes * MaxNodes;

  logic [WeightBits-1:0] mem_q [Depth];
  logic [WeightBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (rd_req_i.en) begin
      rdata_q <= mem_q[rd_req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/pmst_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmst_core: Prim sequencer
// Key, tree-flag and parent arrays walked one node per step through a shared
// less-than compare; running total through one adder; output register.
// ----------------------------------------------------------------------------
module pmst_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [pmst_pkg::CntW-1:0]        node_cnt_i,
  output logic                             busy_o,
  output pmst_pkg::pmst_rd_req_t           rd_req_o,
  input  logic [pmst_pkg::WeightBits-1:0]  rdata_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output pmst_pkg::pmst_out_t              out_data_o
);
  import pmst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_FIND,
    ST_PICK,
    ST_RLX_RD,
    ST_RLX_UPD,
    ST_OUT_RD,
    ST_OUT_WR
  } state_e;

  state_e                state_q, state_d;
  logic [NodeW-1:0]      idx_q, idx_d;
  logic [NodeW-1:0]      pass_q, pass_d;
  logic [NodeW-1:0]      pick_q, pick_d;
  logic [KeyW-1:0]       best_q, best_d;
  logic                  found_q, found_d;
  logic [MaxNodes-1:0]   intree_q, intree_d;
  logic [SumW-1:0]       sum_q, sum_d;
  logic                  out_valid_q, out_valid_d;
  pmst_out_t             out_q, out_d;

  logic [KeyW-1:0]       key_q [MaxNodes];
  logic [NodeW-1:0]      parent_q [MaxNodes];

  logic [NodeW-1:0]      last_idx;
  logic [KeyW-1:0]       key_cur;
  logic                  tree_cur;
  logic [NodeW-1:0]      parent_cur;
  logic [KeyW-1:0]       cmp_a, cmp_b;
  logic                  cmp_lt;
  logic                  relax_hit;
  logic                  reach;
  logic [WeightBits-1:0] edge_w;
  logic [SumW-1:0]       sum_next;
  logic                  out_free;
  logic                  out_load;

  always_comb begin
    if (node_cnt_i == '0) begin
      last_idx = '0;
    end else if (node_cnt_i > CntW'(MaxNodes)) begin
      last_idx = NodeW'(MaxNodes - 1);
    end else begin
      last_idx = NodeW'(node_cnt_i - CntW'(1));
    end
  end

  assign key_cur    = key_q[idx_q];
  assign tree_cur   = intree_q[idx_q];
  assign parent_cur = parent_q[idx_q];

  // shared compare: candidate key vs best in the scan, new weight vs key in the relax
  assign cmp_a  = (state_q == ST_FIND) ? key_cur : {1'b0, rdata_i};
  assign cmp_b  = (state_q == ST_FIND) ? best_q : key_cur;
  assign cmp_lt = cmp_a < cmp_b;

  assign relax_hit = (rdata_i != '0) && !tree_cur && cmp_lt;

  assign reach    = tree_cur || (key_cur != KeyInf);
  assign edge_w   = reach ? rdata_i : '0;
  assign sum_next = sum_q + SumW'(edge_w);

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == ST_OUT_WR) && out_free;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pass_d      = pass_q;
    pick_d      = pick_q;
    best_d      = best_q;
    found_d     = found_q;
    intree_d    = intree_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    rd_req_o    = '0;

    out_d.child_node   = idx_q;
    out_d.parent_node  = reach ? parent_cur : '0;
    out_d.edge_weight  = edge_w;
    out_d.total_weight = sum_next;
    out_d.reachable    = reach;
    out_d.final_res    = (idx_q == last_idx);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        intree_d = '0;
        sum_d    = '0;
        pass_d   = '0;
        idx_d    = '0;
        best_d   = KeyInf;
        found_d  = 1'b0;
        state_d  = (last_idx == '0) ? ST_IDLE : ST_FIND;
      end
      ST_FIND: begin
        if (!tree_cur && cmp_lt) begin
          best_d  = key_cur;
          pick_d  = idx_q;
          found_d = 1'b1;
        end
        if (idx_q == last_idx) begin
          state_d = ST_PICK;
        end else begin
          idx_d = idx_q + NodeW'(1);
        end
      end
      ST_PICK: begin
        if (!found_q) begin
          idx_d   = NodeW'(1);
          state_d = ST_OUT_RD;
        end else begin
          intree_d[pick_q] = 1'b1;
          idx_d            = '0;
          state_d          = ST_RLX_RD;
        end
      end
      ST_RLX_RD: begin
        rd_req_o.en   = 1'b1;
        rd_req_o.addr = {pick_q, idx_q};
        state_d       = ST_RLX_UPD;
      end
      ST_RLX_UPD: begin
        if (idx_q == last_idx) begin
          if (pass_q + NodeW'(1) == last_idx) begin
            idx_d   = NodeW'(1);
            state_d = ST_OUT_RD;
          end else begin
            pass_d  = pass_q + NodeW'(1);
            idx_d   = '0;
            best_d  = KeyInf;
            found_d = 1'b0;
            state_d = ST_FIND;
          end
        end else begin
          idx_d   = idx_q + NodeW'(1);
          state_d = ST_RLX_RD;
        end
      end
      ST_OUT_RD: begin
        rd_req_o.en   = 1'b1;
        rd_req_o.addr = {idx_q, parent_cur};
        state_d       = ST_OUT_WR;
      end
      ST_OUT_WR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          sum_d       = sum_next;
          if (idx_q == last_idx) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + NodeW'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      pass_q      <= '0;
      pick_q      <= '0;
      best_q      <= KeyInf;
      found_q     <= 1'b0;
      intree_q    <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pass_q      <= pass_d;
      pick_q      <= pick_d;
      best_q      <= best_d;
      found_q     <= found_d;
      intree_q    <= intree_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        out_q <= out_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_INIT) begin
      for (int k = 0; k < MaxNodes; k++) begin
        key_q[k]    <= KeyInf;
        parent_q[k] <= '0;
      end
      key_q[0] <= '0;
    end else if ((state_q == ST_RLX_UPD) && relax_hit) begin
      key_q[idx_q]    <= {1'b0, rdata_i};
      parent_q[idx_q] <= pick_q;
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/prim_mst_dense_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prim_mst_dense_matrix: minimum spanning tree over a dense weight matrix
// Loads matrix entries, then runs Prim from node 0 and streams tree edges.
// ----------------------------------------------------------------------------
// Input beats carry one matrix entry (row, col, weight; weight 0 = no edge)
// and are taken one per cycle while in_ready_o is high. The beat flagged last
// starts the tree run; in_ready_o then stays low until the final result has
// been loaded into the output register.
// For n active nodes the sequencer makes up to n-1 passes (fewer once no node
// outside the tree is reachable): a scan of the key array through one
// comparator, a pick step, and a relax with one weight-store read and one
// compare per node. Results follow in node order 1..n-1, each a store read
// then an output write adding to the total; the last is flagged final_res.
// Unreachable nodes have reachable low and weight 0. A stalled receiver holds
// the output register; the sequencer waits on it. Reset sets node_count to
// 32 and empties the output; the weight store holds nothing defined until written.
// The user must write node_count via cfg_we_i only while idle; not enforced.
// ----------------------------------------------------------------------------
module prim_mst_dense_matrix (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  pmst_pkg::pmst_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pmst_pkg::pmst_out_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [pmst_pkg::CntW-1:0]  cfg_wdata_i
);
  import pmst_pkg::*;

  logic [CntW-1:0]       node_count_q;
  logic                  in_beat;
  logic                  busy;
  pmst_rd_req_t          rd_req;
  logic [WeightBits-1:0] rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountReset;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = !busy;
  assign in_beat    = in_valid_i && in_ready_o;

  pmst_wmem u_wmem (
    .clk_i    (clk_i),
    .we_i     (in_beat),
    .waddr_i  ({in_data_i.row, in_data_i.col}),
    .wdata_i  (in_data_i.weight),
    .rd_req_i (rd_req),
    .rdata_o  (rdata)
  );

  pmst_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_beat && in_data_i.last),
    .node_cnt_i  (node_count_q),
    .busy_o      (busy),
    .rd_req_o    (rd_req),
    .rdata_i     (rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
